/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; all checks run on the rising clock edge
// and are held off while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/ujr_pkg.sv */
package ujr_pkg;

	// Default widths
	localparam int POSITION_WIDTH_DEF = 32;
	localparam int TIMER_WIDTH_DEF    = 16;

	// Fixed field widths
	localparam int DISP_W     = 31;
	localparam int VEL_W      = 31;
	localparam int WAIT_W     = 16;
	localparam int TARGET_W   = 8;
	localparam int ELAPSED_W  = 8;
	localparam int PASS_W     = 9;
	localparam int VEL_OUT_W  = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// Register reset values
	localparam logic [DISP_W-1:0]   DISP_RST   = DISP_W'(65536);
	localparam logic [VEL_W-1:0]    VEL_RST    = VEL_W'(65536);
	localparam logic [WAIT_W-1:0]   WAIT_RST   = WAIT_W'(1000);
	localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(3);

	localparam logic [PASS_W-1:0] PASS_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BACK  = 2'd1,
		PH_FWD   = 2'd2,
		PH_CLEAR = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_END   = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISP   = 2'd0,
		REG_VEL    = 2'd1,
		REG_WAIT   = 2'd2,
		REG_TARGET = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DISP_W-1:0]   disp;
		logic [VEL_W-1:0]    vel;
		logic [WAIT_W-1:0]   max_wait;
		logic [TARGET_W-1:0] target;
	} cfg_t;

	typedef struct packed {
		phase_t              phase;
		logic                fwd_done;
		logic                bwd_done;
		logic [PASS_W-1:0]   passes;
		logic [VEL_OUT_W-1:0] drive;
	} ctrl_t;

	typedef struct packed {
		logic [VEL_OUT_W-1:0] velocity;
		phase_t               phase;
		logic                 finished;
		logic                 clear_jam;
	} res_t;

endpackage

/* rtl/ujr_cfg.sv */
module ujr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ujr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ujr_pkg::CFG_DATA_W-1:0]      cfg_data,
	output ujr_pkg::cfg_t                       cfg
);

	ujr_pkg::cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disp     <= ujr_pkg::DISP_RST;
			cfg_q.vel      <= ujr_pkg::VEL_RST;
			cfg_q.max_wait <= ujr_pkg::WAIT_RST;
			cfg_q.target   <= ujr_pkg::TARGET_RST;
		end else if (cfg_valid) begin
			case (ujr_pkg::reg_idx_t'(cfg_index))
				ujr_pkg::REG_DISP:   cfg_q.disp     <= cfg_data[ujr_pkg::DISP_W-1:0];
				ujr_pkg::REG_VEL:    cfg_q.vel      <= cfg_data[ujr_pkg::VEL_W-1:0];
				ujr_pkg::REG_WAIT:   cfg_q.max_wait <= cfg_data[ujr_pkg::WAIT_W-1:0];
				ujr_pkg::REG_TARGET: cfg_q.target   <= cfg_data[ujr_pkg::TARGET_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/ujr_step.sv */
module ujr_step #(
	parameter int POSITION_WIDTH = ujr_pkg::POSITION_WIDTH_DEF,
	parameter int TIMER_WIDTH    = ujr_pkg::TIMER_WIDTH_DEF
) (
	input  ujr_pkg::cfg_t                    cfg,
	input  logic [1:0]                       mode,
	input  logic signed [POSITION_WIDTH-1:0] position,
	input  logic                             online,
	input  logic [ujr_pkg::ELAPSED_W-1:0]    elapsed_ms,
	input  ujr_pkg::ctrl_t                   ctrl,
	input  logic signed [POSITION_WIDTH-1:0] start_pos,
	input  logic [TIMER_WIDTH-1:0]           timer,
	output ujr_pkg::ctrl_t                   ctrl_nxt,
	output logic signed [POSITION_WIDTH-1:0] start_pos_nxt,
	output logic [TIMER_WIDTH-1:0]           timer_nxt,
	output ujr_pkg::res_t                    res
);

	// Compare widths wide enough that nothing overflows
	localparam int CW  = ((POSITION_WIDTH > ujr_pkg::DISP_W) ? POSITION_WIDTH
		: ujr_pkg::DISP_W) + 2;
	localparam int TCW = (TIMER_WIDTH > ujr_pkg::WAIT_W) ? TIMER_WIDTH : ujr_pkg::WAIT_W;

	logic signed [CW-1:0]          pos_x;
	logic signed [CW-1:0]          start_x;
	logic signed [CW-1:0]          bwd_thresh;
	logic                          bwd_hit;
	logic                          fwd_hit;
	logic [TIMER_WIDTH:0]          timer_sum;
	logic [TIMER_WIDTH-1:0]        timer_adv;
	logic                          expired;
	logic [ujr_pkg::VEL_OUT_W-1:0] vel_pos;
	logic [ujr_pkg::VEL_OUT_W-1:0] vel_neg;
	logic [ujr_pkg::PASS_W-1:0]    passes_inc;
	logic                          clear_pulse;

	// Position thresholds
	assign pos_x      = CW'(position);
	assign start_x    = CW'(start_pos);
	assign bwd_thresh = start_x - $signed(CW'(cfg.disp));
	assign bwd_hit    = pos_x <= bwd_thresh;
	assign fwd_hit    = pos_x >= start_x;

	// Saturating timer and expiry
	assign timer_sum = (TIMER_WIDTH+1)'(timer) + (TIMER_WIDTH+1)'(elapsed_ms);
	assign timer_adv = timer_sum[TIMER_WIDTH] ? '1 : timer_sum[TIMER_WIDTH-1:0];
	assign expired   = TCW'(timer_adv) >= TCW'(cfg.max_wait);

	// Drive values and pass count
	assign vel_pos    = ujr_pkg::VEL_OUT_W'(cfg.vel);
	assign vel_neg    = ujr_pkg::VEL_OUT_W'(0) - vel_pos;
	assign passes_inc = (ctrl.passes == ujr_pkg::PASS_MAX) ? ctrl.passes
		: ctrl.passes + ujr_pkg::PASS_W'(1);

	// Next state
	always_comb begin
		ctrl_nxt      = ctrl;
		start_pos_nxt = start_pos;
		timer_nxt     = timer;
		clear_pulse   = 1'b0;
		case (ujr_pkg::mode_t'(mode))
			ujr_pkg::MODE_START: begin
				start_pos_nxt     = position;
				ctrl_nxt.fwd_done = 1'b0;
				ctrl_nxt.bwd_done = 1'b0;
				ctrl_nxt.passes   = ujr_pkg::PASS_W'(1);
				ctrl_nxt.phase    = ujr_pkg::PH_BACK;
				ctrl_nxt.drive    = vel_neg;
				timer_nxt         = '0;
			end
			ujr_pkg::MODE_TICK: begin
				timer_nxt = timer_adv;
				if (ctrl.phase == ujr_pkg::PH_BACK) begin
					if (bwd_hit || expired) begin
						ctrl_nxt.bwd_done = ctrl.bwd_done | bwd_hit;
						ctrl_nxt.phase    = ujr_pkg::PH_FWD;
						ctrl_nxt.drive    = vel_pos;
						timer_nxt         = '0;
					end
				end else if (ctrl.phase == ujr_pkg::PH_FWD) begin
					if (fwd_hit || expired) begin
						ctrl_nxt.fwd_done = ctrl.fwd_done | fwd_hit;
						ctrl_nxt.phase    = ujr_pkg::PH_BACK;
						ctrl_nxt.drive    = vel_neg;
						ctrl_nxt.passes   = passes_inc;
						timer_nxt         = '0;
					end
				end
				// Both thresholds seen while rocking: jam cleared
				if ((ctrl_nxt.phase == ujr_pkg::PH_BACK || ctrl_nxt.phase == ujr_pkg::PH_FWD)
						&& ctrl_nxt.fwd_done && ctrl_nxt.bwd_done) begin
					ctrl_nxt.phase = ujr_pkg::PH_CLEAR;
				end
			end
			ujr_pkg::MODE_END: begin
				clear_pulse    = ctrl.phase == ujr_pkg::PH_CLEAR;
				ctrl_nxt.drive = '0;
				ctrl_nxt.phase = ujr_pkg::PH_IDLE;
			end
			default: begin
			end
		endcase
	end

	// Result item
	assign res.velocity  = ctrl_nxt.drive;
	assign res.phase     = ctrl_nxt.phase;
	assign res.finished  = !online || ctrl_nxt.phase == ujr_pkg::PH_CLEAR
		|| ctrl_nxt.passes > ujr_pkg::PASS_W'(cfg.target);
	assign res.clear_jam = clear_pulse;

endmodule

/* rtl/unjam_rotate_sequencer_top.sv */
// Unjam sequencer: rocks a jammed motor backward and forward around the position
// latched by a start item, turning on displacement or timeout, until both
// directions have cleared (phase 3), and reports velocity, phase, finished and a
// clear_jam pulse on end. One result item per input item. Throughput is one
// item per clock while out_ready does not stall the result register. An item
// passes the input register, then the single-pass step logic into the result
// register; a new item is taken while a result waits for out_ready. Config
// writes are always ready and must only be issued while the block is idle.
`include "assert_macros.svh"

module unjam_rotate_sequencer_top #(
	parameter int POSITION_WIDTH = ujr_pkg::POSITION_WIDTH_DEF,
	parameter int TIMER_WIDTH    = ujr_pkg::TIMER_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ujr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ujr_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic signed [POSITION_WIDTH-1:0]      position,
	input  logic                                  online,
	input  logic [ujr_pkg::ELAPSED_W-1:0]         elapsed_ms,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ujr_pkg::VEL_OUT_W-1:0]  velocity_setpoint,
	output logic [1:0]                            phase,
	output logic                                  finished,
	output logic                                  clear_jam
);

	ujr_pkg::cfg_t                    cfg;

	logic                             valid_s1;
	logic [1:0]                       mode_s1;
	logic signed [POSITION_WIDTH-1:0] position_s1;
	logic                             online_s1;
	logic [ujr_pkg::ELAPSED_W-1:0]    elapsed_s1;

	ujr_pkg::ctrl_t                   ctrl_q;
	logic signed [POSITION_WIDTH-1:0] start_pos_q;
	logic [TIMER_WIDTH-1:0]           timer_q;

	ujr_pkg::ctrl_t                   ctrl_nxt;
	logic signed [POSITION_WIDTH-1:0] start_pos_nxt;
	logic [TIMER_WIDTH-1:0]           timer_nxt;
	ujr_pkg::res_t                    res;

	logic                             out_valid_q;
	ujr_pkg::res_t                    res_q;
	logic                             advance;

	ujr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ujr_step #(
		.POSITION_WIDTH (POSITION_WIDTH),
		.TIMER_WIDTH    (TIMER_WIDTH)
	) u_step (
		.cfg           (cfg),
		.mode          (mode_s1),
		.position      (position_s1),
		.online        (online_s1),
		.elapsed_ms    (elapsed_s1),
		.ctrl          (ctrl_q),
		.start_pos     (start_pos_q),
		.timer         (timer_q),
		.ctrl_nxt      (ctrl_nxt),
		.start_pos_nxt (start_pos_nxt),
		.timer_nxt     (timer_nxt),
		.res           (res)
	);

	// Handshake: stage 1 moves when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1     <= mode;
			position_s1 <= position;
			online_s1   <= online;
			elapsed_s1  <= elapsed_ms;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.phase    <= ujr_pkg::PH_IDLE;
			ctrl_q.fwd_done <= 1'b0;
			ctrl_q.bwd_done <= 1'b0;
			ctrl_q.passes   <= '0;
			ctrl_q.drive    <= '0;
			start_pos_q     <= '0;
			timer_q         <= '0;
		end else if (advance) begin
			ctrl_q      <= ctrl_nxt;
			start_pos_q <= start_pos_nxt;
			timer_q     <= timer_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign velocity_setpoint = $signed(res_q.velocity);
	assign phase             = res_q.phase;
	assign finished          = res_q.finished;
	assign clear_jam         = res_q.clear_jam;

	// Checks
	`ASSERT_IMPLIES(a_clear_only_at_idle, clk, arst_n,
		out_valid_q && res_q.clear_jam, res_q.phase == ujr_pkg::PH_IDLE)
	`ASSERT_IMPLIES(a_cleared_is_finished, clk, arst_n,
		out_valid_q && res_q.phase == ujr_pkg::PH_CLEAR, res_q.finished)
	`ASSERT_IMPLIES(a_idle_no_drive, clk, arst_n,
		ctrl_q.phase == ujr_pkg::PH_IDLE, ctrl_q.drive == '0)
	`ASSERT_IMPLIES(a_active_has_pass, clk, arst_n,
		ctrl_q.phase != ujr_pkg::PH_IDLE, ctrl_q.passes != '0)
	`ASSERT_NEXT(a_result_after_advance, clk, arst_n, advance, out_valid_q)

endmodule

/* tb/unjam_rotate_sequencer_top_tb.sv */
`timescale 1ns / 100ps

module unjam_rotate_sequencer_top_tb;

	localparam int POS_W   = ujr_pkg::POSITION_WIDTH_DEF;
	localparam int TIMER_W = ujr_pkg::TIMER_WIDTH_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLDOFF_CYCLES = 200;

	typedef struct {
		logic [1:0]                        mode;
		logic signed [POS_W-1:0]           position;
		logic                              online;
		logic [ujr_pkg::ELAPSED_W-1:0]     elapsed;
	} stim_item_t;

	typedef struct {
		logic signed [ujr_pkg::VEL_OUT_W-1:0] velocity;
		ujr_pkg::phase_t                      phase;
		logic                                 finished;
		logic                                 clear_jam;
	} seq_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// block ports
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [ujr_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
	logic [ujr_pkg::CFG_DATA_W-1:0]        cfg_data = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic [1:0]                            mode = '0;
	logic signed [POS_W-1:0]               position = '0;
	logic                                  online = 1'b0;
	logic [ujr_pkg::ELAPSED_W-1:0]         elapsed_ms = '0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic signed [ujr_pkg::VEL_OUT_W-1:0]  velocity_setpoint;
	logic [1:0]                            phase;
	logic                                  finished;
	logic                                  clear_jam;

	unjam_rotate_sequencer_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.position          (position),
		.online            (online),
		.elapsed_ms        (elapsed_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.velocity_setpoint (velocity_setpoint),
		.phase             (phase),
		.finished          (finished),
		.clear_jam         (clear_jam)
	);

	// stimulus and scoreboard storage
	stim_item_t  pending_items[$];
	seq_result_t expected_results[$];
	stim_item_t  next_item;
	seq_result_t want;
	int items_sent = 0;
	int items_taken = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_reqs = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;

	// shadow configuration
	logic [ujr_pkg::DISP_W-1:0]   disp_cfg   = ujr_pkg::DISP_RST;
	logic [ujr_pkg::VEL_W-1:0]    vel_cfg    = ujr_pkg::VEL_RST;
	logic [ujr_pkg::WAIT_W-1:0]   wait_cfg   = ujr_pkg::WAIT_RST;
	logic [ujr_pkg::TARGET_W-1:0] target_cfg = ujr_pkg::TARGET_RST;

	// shadow sequencer state
	ujr_pkg::phase_t             ph_q      = ujr_pkg::PH_IDLE;
	logic signed [POS_W-1:0]     anchor_q  = '0;
	logic                        fwd_ok_q  = 1'b0;
	logic                        bwd_ok_q  = 1'b0;
	logic [ujr_pkg::PASS_W-1:0]  passes_q  = '0;
	logic [TIMER_W-1:0]          timer_q   = '0;
	logic signed [ujr_pkg::VEL_OUT_W-1:0] drive_q = '0;

	function automatic void turn_backward();
		timer_q = '0;
		drive_q = -$signed({1'b0, vel_cfg});
		ph_q = ujr_pkg::PH_BACK;
		if (passes_q != ujr_pkg::PASS_MAX)
			passes_q = passes_q + ujr_pkg::PASS_W'(1);
	endfunction

	function automatic void turn_forward();
		timer_q = '0;
		drive_q = $signed({1'b0, vel_cfg});
		ph_q = ujr_pkg::PH_FWD;
	endfunction

	// one input item through the sequencer, returns its result item
	function automatic seq_result_t advance_sequencer(input logic [1:0] m,
			input logic signed [POS_W-1:0] pos, input logic on,
			input logic [ujr_pkg::ELAPSED_W-1:0] ms);
		seq_result_t r;
		logic [TIMER_W:0] sum;
		logic expired;
		r.clear_jam = 1'b0;
		case (m)
			ujr_pkg::MODE_START: begin
				anchor_q = pos;
				fwd_ok_q = 1'b0;
				bwd_ok_q = 1'b0;
				passes_q = '0;
				turn_backward();
			end
			ujr_pkg::MODE_TICK: begin
				sum = {1'b0, timer_q} + (TIMER_W+1)'(ms);
				timer_q = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
				expired = (timer_q >= wait_cfg);
				if (ph_q == ujr_pkg::PH_BACK) begin
					if (longint'(pos) <= longint'(anchor_q) - longint'(disp_cfg)) begin
						bwd_ok_q = 1'b1;
						turn_forward();
					end else if (expired) begin
						turn_forward();
					end
				end else if (ph_q == ujr_pkg::PH_FWD) begin
					if (longint'(pos) >= longint'(anchor_q)) begin
						fwd_ok_q = 1'b1;
						turn_backward();
					end else if (expired) begin
						turn_backward();
					end
				end
				if (ph_q != ujr_pkg::PH_CLEAR && ph_q != ujr_pkg::PH_IDLE
						&& fwd_ok_q && bwd_ok_q)
					ph_q = ujr_pkg::PH_CLEAR;
			end
			ujr_pkg::MODE_END: begin
				r.clear_jam = (ph_q == ujr_pkg::PH_CLEAR);
				drive_q = '0;
				ph_q = ujr_pkg::PH_IDLE;
			end
			default: ;
		endcase
		r.velocity = drive_q;
		r.phase = ph_q;
		r.finished = !on || ph_q == ujr_pkg::PH_CLEAR || passes_q > {1'b0, target_cfg};
		return r;
	endfunction

	// input driver: presents queued items, idles at random between them
	always @(negedge clk) begin
		if (arst_n && (!in_valid || items_taken == items_sent)) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				mode <= next_item.mode;
				position <= next_item.position;
				online <= next_item.online;
				elapsed_ms <= next_item.elapsed;
				in_valid <= 1'b1;
				items_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (holdoff_seen != holdoff_reqs) begin
			holdoff_seen = holdoff_reqs;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor: register writes, predictions on accepted items, result checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (ujr_pkg::reg_idx_t'(cfg_index))
					ujr_pkg::REG_DISP:   disp_cfg = cfg_data[ujr_pkg::DISP_W-1:0];
					ujr_pkg::REG_VEL:    vel_cfg = cfg_data[ujr_pkg::VEL_W-1:0];
					ujr_pkg::REG_WAIT:   wait_cfg = cfg_data[ujr_pkg::WAIT_W-1:0];
					ujr_pkg::REG_TARGET: target_cfg = cfg_data[ujr_pkg::TARGET_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				items_taken++;
				expected_results.push_back(advance_sequencer(mode, position, online,
					elapsed_ms));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item: vel %0d phase %0d fin %0b clr %0b",
							velocity_setpoint, phase, finished, clear_jam);
				end else begin
					want = expected_results.pop_front();
					if (velocity_setpoint !== want.velocity || phase !== want.phase ||
							finished !== want.finished || clear_jam !== want.clear_jam) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: vel %0d/%0d phase %0d/%0d fin %0b/%0b clr %0b/%0b",
								want.velocity, velocity_setpoint, want.phase, phase,
								want.finished, finished, want.clear_jam, clear_jam);
					end
				end
			end
		end
	end

	task automatic push_item(input logic [1:0] m, input logic [POS_W-1:0] pos,
			input logic on, input logic [ujr_pkg::ELAPSED_W-1:0] ms);
		stim_item_t it;
		it.mode = m;
		it.position = pos;
		it.online = on;
		it.elapsed = ms;
		pending_items.push_back(it);
	endtask

	task automatic write_register(input ujr_pkg::reg_idx_t idx,
			input logic [ujr_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// unused upper data bits are filled with noise; the block keeps only the field
	task automatic apply_settings(input logic [ujr_pkg::DISP_W-1:0] d,
			input logic [ujr_pkg::VEL_W-1:0] v, input logic [ujr_pkg::WAIT_W-1:0] w,
			input logic [ujr_pkg::TARGET_W-1:0] t);
		write_register(ujr_pkg::REG_DISP, {1'($urandom), d});
		write_register(ujr_pkg::REG_VEL, {1'($urandom), v});
		write_register(ujr_pkg::REG_WAIT, {16'($urandom), w});
		write_register(ujr_pkg::REG_TARGET, {24'($urandom), t});
	endtask

	task automatic wait_until_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || items_taken != items_sent ||
			expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// position near the thresholds of a sequence anchored at origin
	function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] origin);
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1, 2, 3: return origin - {1'b0, disp_cfg} - POS_W'($urandom_range(0, 3));
			4:       return origin - {1'b0, disp_cfg} + POS_W'(1);
			5, 6:    return origin + POS_W'($urandom_range(0, 3));
			7:       return origin - POS_W'(1);
			default: return origin - POS_W'($urandom_range(0, {1'b0, disp_cfg}));
		endcase
	endfunction

	// mostly start/tick/end sequences, with noise and broken sequences mixed in
	task automatic queue_random_traffic(input int count);
		int pushed;
		int ticks;
		logic [POS_W-1:0] origin;
		pushed = 0;
		while (pushed < count) begin
			if ($urandom_range(0, 9) < 8) begin
				origin = $urandom;
				ticks = $urandom_range(2, 14);
				push_item(ujr_pkg::MODE_START, origin, $urandom_range(0, 9) != 0,
					ujr_pkg::ELAPSED_W'($urandom));
				for (int k = 0; k < ticks; k++)
					push_item(ujr_pkg::MODE_TICK, pick_position(origin),
						$urandom_range(0, 9) != 0,
						ujr_pkg::ELAPSED_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
							: $urandom_range(0, 40)));
				pushed += ticks + 1;
				if ($urandom_range(0, 7) != 0) begin
					push_item(ujr_pkg::MODE_END, pick_position(origin),
						$urandom_range(0, 9) != 0, ujr_pkg::ELAPSED_W'($urandom));
					pushed++;
				end
			end else begin
				push_item(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
					ujr_pkg::ELAPSED_W'($urandom));
				pushed++;
			end
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset settings, every mode, both turn causes, clear and end
		push_item(MODE_UNUSED, 32'h0, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_TICK, 32'h0, 1'b1, 8'd255);
		push_item(ujr_pkg::MODE_END, 32'h0, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_START, 32'h0, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_TICK, 32'h0, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_TICK, -32'sd65536, 1'b1, 8'd10);
		push_item(ujr_pkg::MODE_TICK, -32'sd1, 1'b1, 8'd255);
		push_item(MODE_UNUSED, 32'h0, 1'b1, 8'd255);
		push_item(ujr_pkg::MODE_TICK, 32'h0, 1'b1, 8'd1);
		push_item(ujr_pkg::MODE_TICK, 32'h8000_0000, 1'b1, 8'd255);
		push_item(ujr_pkg::MODE_END, 32'h0, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_START, 32'h8000_0000, 1'b0, 8'd255);
		repeat (4) push_item(ujr_pkg::MODE_TICK, 32'h8000_0000, 1'b1, 8'd255);
		push_item(ujr_pkg::MODE_TICK, 32'h7FFF_FFFF, 1'b1, 8'd0);
		repeat (4) push_item(ujr_pkg::MODE_TICK, 32'h7FFF_FFFF, 1'b0, 8'd255);
		push_item(ujr_pkg::MODE_TICK, 32'h7FFF_FFFF, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_START, 32'h7FFF_FFFF, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_START, 32'h5555_AAAA, 1'b1, 8'd0);
		push_item(ujr_pkg::MODE_END, 32'h7FFF_FFFF, 1'b1, 8'd0);
		wait_until_drained();

		// random settings, no idling, long receiver hold-off, pause mid-phase
		apply_settings(ujr_pkg::DISP_W'($urandom_range(1, 200000)),
			ujr_pkg::VEL_W'($urandom_range(0, 32'h7FFF_FFFF)),
			ujr_pkg::WAIT_W'($urandom_range(100, 700)),
			ujr_pkg::TARGET_W'($urandom_range(1, 4)));
		queue_random_traffic(30);
		holdoff_reqs++;
		wait_until_drained();
		queue_random_traffic(30);
		wait_until_drained();

		// largest settings, sender idling: timer runs into saturation
		send_idle_pct = 79;
		apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 8'hFF);
		push_item(ujr_pkg::MODE_START, 32'h0, 1'b1, 8'd0);
		repeat (262) push_item(ujr_pkg::MODE_TICK, 32'h0, 1'b1, 8'd255);
		push_item(ujr_pkg::MODE_END, 32'h0, 1'b1, 8'd0);
		queue_random_traffic(10);
		wait_until_drained();

		// smallest settings, receiver stalling
		send_idle_pct = 0;
		stall_pct = 79;
		apply_settings(31'd1, 31'd0, 16'd1, 8'd1);
		queue_random_traffic(45);
		wait_until_drained();

		// zero displacement and zero wait: every tick while rocking turns; both sides idle
		send_idle_pct = 19;
		stall_pct = 19;
		apply_settings(31'd0, ujr_pkg::VEL_W'($urandom_range(0, 32'h7FFF_FFFF)), 16'd0,
			ujr_pkg::TARGET_W'($urandom_range(1, 255)));
		queue_random_traffic(45);
		wait_until_drained();

		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
